FILE: rtl/core/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked property, off while reset is low
`define RTMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset too
`define RTMQ_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RTMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTMQ_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/core/rtmq_pkg.sv
// shared types and constants for the matrix to quaternion converter
package rtmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int M_W           = 16;
    localparam int Q_W           = 16;
    localparam int D_W           = 18;
    localparam int MIN_W         = 15;
    localparam int CFG_W         = 32;
    localparam int ADDR_W        = 2;
    localparam int DIV_LAT       = Q_W + 1;

    localparam logic [ADDR_W-1:0] REG_MIN_DEN = '0;
    localparam logic [MIN_W-1:0]  MIN_DEN_RST = 15'd1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOCASE = 2'd1,
        ST_SMALL  = 2'd2
    } t_status;

    // which component is the half denominator
    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } t_sel;

    typedef struct packed {
        t_sel           sel;
        t_status        status;
        logic [Q_W-1:0] half;
    } t_side;

endpackage

FILE: rtl/core/rtmq_sqrt.sv
// pipelined integer square root, one root bit per stage
module rtmq_sqrt #(
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [2*DW-1:0] i_rad,
    output logic [DW-1:0] o_root
);
    localparam int RMW = DW + 3;

    logic [RMW-1:0]  r_rem  [DW];
    logic [DW-1:0]   r_root [DW];
    logic [2*DW-1:0] r_rad  [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [RMW-1:0]  p_rem;
        logic [DW-1:0]   p_root;
        logic [2*DW-1:0] p_rad;
        logic [RMW-1:0]  t_rem;
        logic [RMW-1:0]  trial;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
        end

        always_comb begin
            t_rem = {p_rem[RMW-3:0], p_rad[2*DW-1:2*DW-2]};
            trial = {1'b0, p_root, 2'b01};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k] <= p_rad << 2;
                if (t_rem >= trial) begin
                    r_rem[k]  <= t_rem - trial;
                    r_root[k] <= {p_root[DW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= t_rem;
                    r_root[k] <= {p_root[DW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[DW-1];

endmodule

FILE: rtl/core/rtmq_div.sv
// pipelined signed quotient (d << frac) / (2 den), saturated to the output width
module rtmq_div #(
    parameter int FRAC_BITS = rtmq_pkg::FRAC_BITS_DEF,
    parameter int DW        = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [rtmq_pkg::D_W-1:0] i_d,
    input  logic [DW-1:0]                 i_den,
    output logic signed [rtmq_pkg::Q_W-1:0] o_q
);
    import rtmq_pkg::*;

    localparam int QB  = Q_W - 1;
    localparam int MW  = D_W - 1 + FRAC_BITS;
    localparam int HW  = MW - QB;
    localparam int VW  = DW + 1;
    localparam int CMW = (HW > VW) ? HW : VW;

    logic [D_W-1:0] d_abs;
    logic [MW-1:0]  mag;
    logic [VW-1:0]  divisor;
    logic           ovf;

    always_comb begin
        d_abs   = i_d[D_W-1] ? D_W'(-i_d) : D_W'(i_d);
        mag     = {d_abs[D_W-2:0], {FRAC_BITS{1'b0}}};
        divisor = {i_den, 1'b0};
        ovf     = CMW'(mag[MW-1:QB]) >= CMW'(divisor);
    end

    // entry stage
    logic [VW-1:0] r_rem0;
    logic [QB-1:0] r_lo0;
    logic [VW-1:0] r_div0;
    logic          r_neg0;
    logic          r_ovf0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= VW'(mag[MW-1:QB]);
            r_lo0  <= mag[QB-1:0];
            r_div0 <= divisor;
            r_neg0 <= i_d[D_W-1];
            r_ovf0 <= ovf;
        end
    end

    logic [VW-1:0] r_rem [QB];
    logic [QB-1:0] r_lo  [QB];
    logic [QB-1:0] r_qb  [QB];
    logic [VW-1:0] r_div [QB];
    logic          r_neg [QB];
    logic          r_ovf [QB];

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [VW-1:0] p_rem;
        logic [QB-1:0] p_lo;
        logic [QB-1:0] p_qb;
        logic [VW-1:0] p_div;
        logic          p_neg;
        logic          p_ovf;
        logic [VW:0]   t_rem;

        if (j == 0) begin : g_first
            assign p_rem = r_rem0;
            assign p_lo  = r_lo0;
            assign p_qb  = '0;
            assign p_div = r_div0;
            assign p_neg = r_neg0;
            assign p_ovf = r_ovf0;
        end else begin : g_next
            assign p_rem = r_rem[j-1];
            assign p_lo  = r_lo[j-1];
            assign p_qb  = r_qb[j-1];
            assign p_div = r_div[j-1];
            assign p_neg = r_neg[j-1];
            assign p_ovf = r_ovf[j-1];
        end

        assign t_rem = {p_rem, p_lo[QB-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[j]  <= p_lo << 1;
                r_div[j] <= p_div;
                r_neg[j] <= p_neg;
                r_ovf[j] <= p_ovf;
                if (t_rem >= {1'b0, p_div}) begin
                    r_rem[j] <= VW'(t_rem - {1'b0, p_div});
                    r_qb[j]  <= {p_qb[QB-2:0], 1'b1};
                end else begin
                    r_rem[j] <= VW'(t_rem);
                    r_qb[j]  <= {p_qb[QB-2:0], 1'b0};
                end
            end
        end
    end

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {QB{1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {QB{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[QB-1]) begin
                o_q <= r_neg[QB-1] ? Q_MIN : Q_MAX;
            end else if (r_neg[QB-1]) begin
                o_q <= -{1'b0, r_qb[QB-1]};
            end else begin
                o_q <= {1'b0, r_qb[QB-1]};
            end
        end
    end

endmodule

FILE: rtl/core/rotation_matrix_to_quaternion_top.sv
// top level: rotation matrix to unit quaternion, fully pipelined
// pipeline stages in order: input, case select, DEN_W root stages,
// 17 divider stages with the denominator check in front, output register
// throughput one request per cycle; the whole pipe holds while the output is stalled
// synchronous active-low reset clears valid bits and sets min_denominator to 1
`include "assert_macros.svh"

module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = rtmq_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [rtmq_pkg::M_W-1:0] i_m_xx,
    input  logic signed [rtmq_pkg::M_W-1:0] i_m_xy,
    input  logic signed [rtmq_pkg::M_W-1:0] i_m_xz,
    input  logic signed [rtmq_pkg::M_W-1:0] i_m_yx,
    input  logic signed [rtmq_pkg::M_W-1:0] i_m_yy,
    input  logic signed [rtmq_pkg::M_W-1:0] i_m_yz,
    input  logic signed [rtmq_pkg::M_W-1:0] i_m_zx,
    input  logic signed [rtmq_pkg::M_W-1:0] i_m_zy,
    input  logic signed [rtmq_pkg::M_W-1:0] i_m_zz,
    // result request channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [rtmq_pkg::Q_W-1:0] o_q_w,
    output logic signed [rtmq_pkg::Q_W-1:0] o_q_x,
    output logic signed [rtmq_pkg::Q_W-1:0] o_q_y,
    output logic signed [rtmq_pkg::Q_W-1:0] o_q_z,
    output logic [1:0]                      o_status,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtmq_pkg::ADDR_W-1:0]     paddr,
    input  logic [rtmq_pkg::CFG_W-1:0]      pwdata,
    output logic [rtmq_pkg::CFG_W-1:0]      prdata,
    output logic                            pready
);
    import rtmq_pkg::*;

    // radicand s = one +- three diagonals, signed
    localparam int SW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    // s << frac, rounded up to an even width
    localparam int RW    = SW - 1 + FRAC_BITS;
    localparam int RWE   = RW + (RW % 2);
    localparam int DEN_W = RWE / 2;
    localparam int CW    = (DEN_W > MIN_W) ? DEN_W : MIN_W;
    localparam int HCW   = (DEN_W > Q_W) ? DEN_W : Q_W;

    localparam logic signed [SW-1:0] ONE =
        {{(SW - 1 - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [HCW-1:0] HALF_MAX = HCW'({1'b0, {(Q_W - 1){1'b1}}});

    // global pipeline advance: hold everything while the output waits
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // ---------------- register port ----------------
    logic [MIN_W-1:0] r_min_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_den <= MIN_DEN_RST;
        end else if (psel && penable && pwrite && paddr == REG_MIN_DEN) begin
            r_min_den <= pwdata[MIN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MIN_DEN) ? CFG_W'(r_min_den) : '0;

    // ---------------- stage 0: input capture ----------------
    logic                  r_in_v;
    logic signed [M_W-1:0] r_in_xx, r_in_xy, r_in_xz;
    logic signed [M_W-1:0] r_in_yx, r_in_yy, r_in_yz;
    logic signed [M_W-1:0] r_in_zx, r_in_zy, r_in_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_xx <= i_m_xx;
            r_in_xy <= i_m_xy;
            r_in_xz <= i_m_xz;
            r_in_yx <= i_m_yx;
            r_in_yy <= i_m_yy;
            r_in_yz <= i_m_yz;
            r_in_zx <= i_m_zx;
            r_in_zy <= i_m_zy;
            r_in_zz <= i_m_zz;
        end
    end

    // ---------------- stage 1: case select, radicand, off-diagonal terms ----------------
    logic signed [M_W:0]  xx, yy, zz;
    logic signed [D_W-1:0] d_zy_yz, d_xz_zx, d_yx_xy, d_xy_yx, d_zx_xz, d_yz_zy;
    logic                  nocase;
    t_sel                  sel;
    logic signed [SW-1:0]  s;
    logic signed [D_W-1:0] d_lane [3];

    always_comb begin
        xx = (M_W + 1)'(r_in_xx);
        yy = (M_W + 1)'(r_in_yy);
        zz = (M_W + 1)'(r_in_zz);

        d_zy_yz = D_W'(r_in_zy) - D_W'(r_in_yz);
        d_xz_zx = D_W'(r_in_xz) - D_W'(r_in_zx);
        d_yx_xy = D_W'(r_in_yx) - D_W'(r_in_xy);
        d_xy_yx = D_W'(r_in_xy) + D_W'(r_in_yx);
        d_zx_xz = D_W'(r_in_zx) + D_W'(r_in_xz);
        d_yz_zy = D_W'(r_in_yz) + D_W'(r_in_zy);

        nocase = 1'b0;
        sel    = SEL_W;
        s      = '0;
        // strict compares: a tie fails its case and falls to the next; none matching is the uncovered case
        if (yy > -zz && xx > -yy && xx > -zz) begin
            sel = SEL_W;
            s   = ONE + SW'(xx) + SW'(yy) + SW'(zz);
        end else if (yy < -zz && xx > yy && xx > zz) begin
            sel = SEL_X;
            s   = ONE + SW'(xx) - SW'(yy) - SW'(zz);
        end else if (yy > zz && xx < yy && xx < -zz) begin
            sel = SEL_Y;
            s   = ONE - SW'(xx) + SW'(yy) - SW'(zz);
        end else if (yy < zz && xx < -yy && xx < zz) begin
            sel = SEL_Z;
            s   = ONE - SW'(xx) - SW'(yy) + SW'(zz);
        end else begin
            nocase = 1'b1;
        end

        // three lanes in w, x, y, z order, skipping the half component
        case (sel)
            SEL_W: begin
                d_lane[0] = d_zy_yz;
                d_lane[1] = d_xz_zx;
                d_lane[2] = d_yx_xy;
            end
            SEL_X: begin
                d_lane[0] = d_zy_yz;
                d_lane[1] = d_xy_yx;
                d_lane[2] = d_zx_xz;
            end
            SEL_Y: begin
                d_lane[0] = d_xz_zx;
                d_lane[1] = d_xy_yx;
                d_lane[2] = d_yz_zy;
            end
            default: begin
                d_lane[0] = d_yx_xy;
                d_lane[1] = d_zx_xz;
                d_lane[2] = d_yz_zy;
            end
        endcase
    end

    logic                  r_cs_v;
    logic                  r_cs_nc;
    t_sel                  r_cs_sel;
    logic signed [SW-1:0]  r_cs_s;
    logic signed [D_W-1:0] r_cs_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_v <= 1'b0;
        end else if (en) begin
            r_cs_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cs_nc  <= nocase;
            r_cs_sel <= sel;
            r_cs_s   <= s;
            r_cs_d   <= d_lane;
        end
    end

    // ---------------- square root stages ----------------
    logic [RWE-1:0]   rad;
    logic [DEN_W-1:0] den;

    // non-positive radicand gives a zero root
    assign rad = (!r_cs_s[SW-1] && r_cs_s != '0)
               ? (RWE'(r_cs_s[SW-2:0]) << FRAC_BITS) : '0;

    rtmq_sqrt #(
        .DW (DEN_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad),
        .o_root (den)
    );

    // sideband travels beside the root stages
    logic                  r_sq_v  [DEN_W];
    logic                  r_sq_nc [DEN_W];
    t_sel                  r_sq_sel[DEN_W];
    logic signed [D_W-1:0] r_sq_d  [DEN_W][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEN_W; k++) begin
                r_sq_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_sq_v[0] <= r_cs_v;
            for (int k = 1; k < DEN_W; k++) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_nc[0]  <= r_cs_nc;
            r_sq_sel[0] <= r_cs_sel;
            r_sq_d[0]   <= r_cs_d;
            for (int k = 1; k < DEN_W; k++) begin
                r_sq_nc[k]  <= r_sq_nc[k-1];
                r_sq_sel[k] <= r_sq_sel[k-1];
                r_sq_d[k]   <= r_sq_d[k-1];
            end
        end
    end

    // ---------------- denominator check and half component ----------------
    logic [HCW-1:0] den_half;
    t_side          side;

    always_comb begin
        den_half = HCW'(den >> 1);
        side.sel = r_sq_sel[DEN_W-1];
        side.half = (den_half > HALF_MAX) ? Q_W'(HALF_MAX) : Q_W'(den_half);
        if (r_sq_nc[DEN_W-1]) begin
            side.status = ST_NOCASE;
        end else if (CW'(den) <= CW'(r_min_den)) begin
            side.status = ST_SMALL;
        end else begin
            side.status = ST_OK;
        end
    end

    // ---------------- divider lanes ----------------
    logic signed [Q_W-1:0] q_lane [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        rtmq_div #(
            .FRAC_BITS (FRAC_BITS),
            .DW        (DEN_W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (r_sq_d[DEN_W-1][i]),
            .i_den (den),
            .o_q   (q_lane[i])
        );
    end

    logic  r_dv [DIV_LAT];
    t_side r_ds [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r_sq_v[DEN_W-1];
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ds[0] <= side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_ds[k] <= r_ds[k-1];
            end
        end
    end

    // ---------------- output assembly ----------------
    t_side                 fin;
    logic signed [Q_W-1:0] n_w, n_x, n_y, n_z;

    always_comb begin
        fin = r_ds[DIV_LAT-1];
        case (fin.sel)
            SEL_W: begin
                n_w = fin.half;
                n_x = q_lane[0];
                n_y = q_lane[1];
                n_z = q_lane[2];
            end
            SEL_X: begin
                n_w = q_lane[0];
                n_x = fin.half;
                n_y = q_lane[1];
                n_z = q_lane[2];
            end
            SEL_Y: begin
                n_w = q_lane[0];
                n_x = q_lane[1];
                n_y = fin.half;
                n_z = q_lane[2];
            end
            default: begin
                n_w = q_lane[0];
                n_x = q_lane[1];
                n_y = q_lane[2];
                n_z = fin.half;
            end
        endcase
        // flagged results carry zero components
        if (fin.status != ST_OK) begin
            n_w = '0;
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_dv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_q_w    <= n_w;
            o_q_x    <= n_x;
            o_q_y    <= n_y;
            o_q_z    <= n_z;
            o_status <= fin.status;
        end
    end

    // ---------------- checks ----------------
    `RTMQ_ASSERT(a_flag_zero, i_clk, i_rst_n,
        (o_valid && o_status != ST_OK) |->
        (o_q_w == '0 && o_q_x == '0 && o_q_y == '0 && o_q_z == '0),
        "flagged result with nonzero component")
    `RTMQ_ASSERT_NR(a_stall_src, i_clk, o_stall |-> (o_valid && i_stall),
        "input stalled without a waiting result")
    `RTMQ_ASSERT(a_accept_moves, i_clk, i_rst_n, (i_valid && !o_stall) |=> r_in_v,
        "accepted request not captured")
    `RTMQ_ASSERT(a_hold_stage, i_clk, i_rst_n, o_stall |=> $stable(r_cs_v),
        "pipeline moved during stall")

endmodule
